### src/gpf_pkg.sv
// Shared types, constants and table builders for the gas sensor ppm filter.
// Used by gpf_div and gas_sensor_ppm_filter_core; depends on nothing else.
package gpf_pkg;

  // Fixed-point and table configuration.
  localparam int PPM_FRAC_BITS     = 4;
  localparam int LOG_TABLE_ENTRIES = 64;
  localparam int IDX_W             = $clog2(LOG_TABLE_ENTRIES);
  localparam int TIX_W             = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int ENT_W             = 18;

  // Register and field widths.
  localparam int REG_W  = 20;
  localparam int RAW_W  = 16;
  localparam int OUT_W  = 18;
  localparam int STAT_W = 2;

  // Serial divider geometry: 52-bit dividend, 36-bit divisor, 24-bit quotient window.
  localparam int DIV_NW   = 52;
  localparam int DIV_DW   = 36;
  localparam int DIV_QW   = 24;
  localparam int DIV_CW   = $clog2(DIV_NW + 1);

  // Sensor and curve constants.
  localparam int SUPPLY_COUNTS = 40000;
  localparam int MIN_COUNTS    = 80;
  localparam int C1_Q16        = 283018;
  localparam int K_Q16         = 139438;
  localparam int ONE_Q16       = 65536;
  localparam int EMA_DIVISOR   = 10;

  // Average and threshold scaling.
  localparam int PPM_CAP  = 10000 << PPM_FRAC_BITS;
  localparam int AVG_W    = $clog2(PPM_CAP + 1);
  localparam int AVG_INIT = 200 << PPM_FRAC_BITS;
  localparam int WARN_TH  = 500 << PPM_FRAC_BITS;
  localparam int CRIT_TH  = 1000 << PPM_FRAC_BITS;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_NORMAL   = 2'd0;
  localparam logic [STAT_W-1:0] ST_WARNING  = 2'd1;
  localparam logic [STAT_W-1:0] ST_CRITICAL = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_LOAD   = 2'd0;
  localparam logic [1:0] REG_CLEAN  = 2'd1;
  localparam logic [1:0] REG_WARMUP = 2'd2;

  typedef logic [LOG_TABLE_ENTRIES:0][ENT_W-1:0] tab_t;

  // Truncated fractional log2 of a Q16 value in [1,2), by repeated squaring.
  function automatic logic [15:0] log2_frac(input logic [31:0] x);
    logic [63:0] z;
    logic [15:0] y;
    z = 64'(x);
    y = '0;
    for (int b = 15; b >= 0; b--) begin
      z = (z * z) >> 16;
      if (z >= 64'(2 * ONE_Q16)) begin
        z = z >> 1;
        y[b] = 1'b1;
      end
    end
    return y;
  endfunction

  // Table of log2(1 + i/N) in Q16.
  function automatic tab_t build_lg();
    tab_t tab;
    logic [31:0] t;
    tab = '0;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      t = 32'((64'(i) << 16) / LOG_TABLE_ENTRIES);
      tab[i] = ENT_W'(log2_frac(32'(ONE_Q16) + t));
    end
    tab[LOG_TABLE_ENTRIES] = ENT_W'(ONE_Q16);
    return tab;
  endfunction

  // Table of 2^(i/N) in Q16: the smallest value whose truncated log reaches i/N.
  function automatic tab_t build_ex();
    tab_t tab;
    logic [31:0] t;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    tab = '0;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      t  = 32'((64'(i) << 16) / LOG_TABLE_ENTRIES);
      lo = 32'(ONE_Q16);
      hi = 32'(2 * ONE_Q16);
      for (int k = 0; k < 20; k++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (32'(log2_frac(mid)) >= t) hi = mid;
          else lo = mid + 32'd1;
        end
      end
      tab[i] = ENT_W'(lo);
    end
    tab[LOG_TABLE_ENTRIES] = ENT_W'(2 * ONE_Q16);
    return tab;
  endfunction

  localparam tab_t LG_TAB = build_lg();
  localparam tab_t EX_TAB = build_ex();

endpackage

### src/gpf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gpf_pkg for its widths.
module gpf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gpf_pkg::DIV_NW-1:0]   dividend,
  input  logic [gpf_pkg::DIV_DW-1:0]   divisor,
  output logic                         done,
  output logic [gpf_pkg::DIV_QW-1:0]   quot,
  output logic                         ovf
);

  logic                         busy;
  logic [gpf_pkg::DIV_CW-1:0]   cnt;
  logic [gpf_pkg::DIV_NW-1:0]   num;
  logic [gpf_pkg::DIV_DW-1:0]   den;
  logic [gpf_pkg::DIV_DW-1:0]   rem;
  logic [gpf_pkg::DIV_DW:0]     rem_sh;
  logic                         take;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem, num[gpf_pkg::DIV_NW-1]};
    take   = rem_sh >= {1'b0, den};
  end

  // Control: busy while the dividend bits are worked, done pulses after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= gpf_pkg::DIV_CW'(gpf_pkg::DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == gpf_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits beyond the window set the overflow flag.
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      num  <= num << 1;
      rem  <= take ? gpf_pkg::DIV_DW'(rem_sh - {1'b0, den}) : rem_sh[gpf_pkg::DIV_DW-1:0];
      quot <= {quot[gpf_pkg::DIV_QW-2:0], take};
      ovf  <= ovf | quot[gpf_pkg::DIV_QW-1];
    end
  end

endmodule

### src/gas_sensor_ppm_filter_core.sv
// Gas concentration filter: warm-up counter, resistance ratio, log/exp curve, moving average.
// Depends on gpf_pkg and gpf_div.
// A tick request only advances the warm-up count; a sample before warm-up ends goes straight to the done state.
// A warm sample shows its result and frees the input at the same time, after
// two 52-step passes through the shared bit-serial divider, up to 23
// normalization shifts and an optional antilog step; one request is worked at a time.
// Synchronous reset restores register defaults, a zero tick count and a 200 ppm average.
module gas_sensor_ppm_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic                          kind,
  input  logic signed [gpf_pkg::RAW_W-1:0] raw_adc,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [gpf_pkg::OUT_W-1:0]     filtered_ppm,
  output logic [gpf_pkg::STAT_W-1:0]    status,
  output logic                          warmed_up,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [gpf_pkg::REG_W-1:0]     wr_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_MUL2   = 4'd2;
  localparam logic [3:0] S_START1 = 4'd3;
  localparam logic [3:0] S_DIV1   = 4'd4;
  localparam logic [3:0] S_NORM   = 4'd5;
  localparam logic [3:0] S_LOG1   = 4'd6;
  localparam logic [3:0] S_LOG2   = 4'd7;
  localparam logic [3:0] S_MULK   = 4'd8;
  localparam logic [3:0] S_EXP1   = 4'd9;
  localparam logic [3:0] S_EXP2   = 4'd10;
  localparam logic [3:0] S_EMA    = 4'd11;
  localparam logic [3:0] S_START2 = 4'd12;
  localparam logic [3:0] S_DIV2   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  localparam int SUM_W = gpf_pkg::AVG_W + 4;
  localparam int VW    = gpf_pkg::ENT_W + gpf_pkg::PPM_FRAC_BITS;

  logic [3:0]                    state;
  logic [gpf_pkg::REG_W-1:0]     load_res;
  logic [gpf_pkg::REG_W-1:0]     clean_res;
  logic [gpf_pkg::REG_W-1:0]     warmup_ms;
  logic [gpf_pkg::REG_W-1:0]     elapsed;
  logic [gpf_pkg::AVG_W-1:0]     avg;
  logic                          warm;
  logic [14:0]                   raw_c;
  logic [gpf_pkg::DIV_DW-1:0]    num;
  logic [gpf_pkg::DIV_NW-1:0]    div_a;
  logic [gpf_pkg::DIV_DW-1:0]    div_d;
  logic                          div_start;
  logic                          div_done;
  logic [gpf_pkg::DIV_QW-1:0]    div_q;
  logic                          div_ovf;
  logic [23:0]                   norm;
  logic [4:0]                    shifts;
  logic [gpf_pkg::ENT_W-1:0]     ta;
  logic [32:0]                   tm;
  logic signed [23:0]            diff;
  logic signed [41:0]            prod;
  logic signed [7:0]             n_int;
  logic [gpf_pkg::AVG_W-1:0]     ppm;
  logic                          accept;

  // Combinational helpers.
  logic [gpf_pkg::REG_W-1:0]     rl_eff;
  logic [gpf_pkg::REG_W-1:0]     ro_eff;
  logic [15:0]                   lfrac;
  logic [16+gpf_pkg::IDX_W-1:0]  lp;
  logic [gpf_pkg::TIX_W-1:0]     lidx;
  logic [gpf_pkg::ENT_W-1:0]     la;
  logic [gpf_pkg::ENT_W-1:0]     lb;
  logic [gpf_pkg::ENT_W-1:0]     lk;
  logic signed [5:0]             e_off;
  logic signed [23:0]            lgr;
  logic signed [27:0]            lpp;
  logic [gpf_pkg::ENT_W-1:0]     ex_val;
  logic [7:0]                    lsh;
  logic [7:0]                    rsh;
  logic [VW-1:0]                 ex_sh;
  logic [SUM_W-1:0]              ema_sum;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign div_start    = (state == S_START1) || (state == S_START2);

  gpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q),
    .ovf      (div_ovf)
  );

  // Table selection, interpolation pieces, curve and shift arithmetic.
  always_comb begin
    rl_eff = (load_res == '0) ? gpf_pkg::REG_W'(1) : load_res;
    ro_eff = (clean_res == '0) ? gpf_pkg::REG_W'(1) : clean_res;
    lfrac  = (state == S_LOG1) ? norm[22:7] : prod[31:16];
    lp     = (16 + gpf_pkg::IDX_W)'(lfrac) * (16 + gpf_pkg::IDX_W)'(gpf_pkg::LOG_TABLE_ENTRIES);
    lidx   = gpf_pkg::TIX_W'(lp[16 +: gpf_pkg::IDX_W]);
    if (state == S_LOG1) begin
      la = gpf_pkg::LG_TAB[lidx];
      lb = gpf_pkg::LG_TAB[lidx + 1'b1];
    end else begin
      la = gpf_pkg::EX_TAB[lidx];
      lb = gpf_pkg::EX_TAB[lidx + 1'b1];
    end
    lk     = ta + gpf_pkg::ENT_W'(tm[32:16]);
    e_off  = 6'sd7 - $signed({1'b0, shifts});
    lgr    = $signed({{2{e_off[5]}}, e_off, 16'd0}) + $signed({6'd0, lk});
    lpp    = 28'(prod >>> 16) + 28'(gpf_pkg::PPM_FRAC_BITS << 16);
    ex_val = lk;
    lsh    = 8'(n_int - 8'sd16);
    rsh    = 8'(8'sd16 - n_int);
    if (n_int >= 8'sd16) ex_sh = VW'(ex_val) << lsh;
    else ex_sh = VW'(ex_val) >> rsh;
    ema_sum = SUM_W'(avg) * SUM_W'(7) + SUM_W'(ppm) * SUM_W'(3) + SUM_W'(5);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_res  <= gpf_pkg::REG_W'(1000);
      clean_res <= gpf_pkg::REG_W'(983);
      warmup_ms <= gpf_pkg::REG_W'(20000);
    end else if (wr_en) begin
      unique case (wr_index)
        gpf_pkg::REG_LOAD:   load_res  <= wr_data;
        gpf_pkg::REG_CLEAN:  clean_res <= wr_data;
        gpf_pkg::REG_WARMUP: warmup_ms <= wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      elapsed      <= '0;
      avg          <= gpf_pkg::AVG_W'(gpf_pkg::AVG_INIT);
      result_valid <= 1'b0;
    end else begin
      // The result register fills as a request leaves and empties when taken.
      if (state == S_DONE && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!kind) begin
              if (elapsed != '1) elapsed <= elapsed + 1'b1;
            end else if (elapsed >= warmup_ms) begin
              state <= S_MUL1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_START1;
        S_START1: state <= S_DIV1;
        S_DIV1:   if (div_done) state <= S_NORM;
        S_NORM:   if (norm[23]) state <= S_LOG1;
        S_LOG1:   state <= S_LOG2;
        S_LOG2:   state <= S_MULK;
        S_MULK:   state <= S_EXP1;
        S_EXP1: begin
          if (lpp >= 28'sd0 + 28'((14 + gpf_pkg::PPM_FRAC_BITS) << 16)) state <= S_EMA;
          else if (lpp < -28'sd2621440) state <= S_EMA;
          else state <= S_EXP2;
        end
        S_EXP2:   state <= S_EMA;
        S_EMA:    state <= S_START2;
        S_START2: state <= S_DIV2;
        S_DIV2: begin
          if (div_done) begin
            avg   <= div_q[gpf_pkg::AVG_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        warm  <= elapsed >= warmup_ms;
        raw_c <= (raw_adc < 16'sd80) ? 15'(gpf_pkg::MIN_COUNTS) : raw_adc[14:0];
      end
      S_MUL1: begin
        num <= gpf_pkg::DIV_DW'(rl_eff) * gpf_pkg::DIV_DW'(16'(gpf_pkg::SUPPLY_COUNTS) - {1'b0, raw_c});
      end
      S_MUL2: begin
        div_a <= {num, 16'd0};
        div_d <= gpf_pkg::DIV_DW'(raw_c) * gpf_pkg::DIV_DW'(ro_eff);
      end
      S_DIV1: begin
        if (div_done) begin
          if (div_ovf) norm <= '1;
          else if (div_q == '0) norm <= 24'd1;
          else norm <= div_q;
          shifts <= '0;
        end
      end
      S_NORM: begin
        if (!norm[23]) begin
          norm   <= norm << 1;
          shifts <= shifts + 1'b1;
        end
      end
      S_LOG1, S_EXP1: begin
        ta <= la;
        tm <= 33'(lb - la) * 33'(lp[15:0]);
        n_int <= lpp[23:16];
        if (state == S_EXP1) begin
          if (lpp >= 28'sd0 + 28'((14 + gpf_pkg::PPM_FRAC_BITS) << 16))
            ppm <= gpf_pkg::AVG_W'(gpf_pkg::PPM_CAP);
          else if (lpp < -28'sd2621440) ppm <= '0;
        end
      end
      S_LOG2: diff <= 24'sd0 + 24'(gpf_pkg::C1_Q16) - lgr;
      S_MULK: prod <= 42'(diff) * $signed({1'b0, 18'(gpf_pkg::K_Q16)});
      S_EXP2: begin
        ppm <= (ex_sh > VW'(gpf_pkg::PPM_CAP)) ? gpf_pkg::AVG_W'(gpf_pkg::PPM_CAP)
                                               : gpf_pkg::AVG_W'(ex_sh);
      end
      S_EMA: begin
        div_a <= gpf_pkg::DIV_NW'(ema_sum);
        div_d <= gpf_pkg::DIV_DW'(gpf_pkg::EMA_DIVISOR);
      end
      default: ;
    endcase
  end

  // Result register, loaded as the request leaves.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || result_ready)) begin
      filtered_ppm <= gpf_pkg::OUT_W'(avg);
      warmed_up    <= warm;
      if (avg > gpf_pkg::AVG_W'(gpf_pkg::CRIT_TH)) status <= gpf_pkg::ST_CRITICAL;
      else if (avg > gpf_pkg::AVG_W'(gpf_pkg::WARN_TH)) status <= gpf_pkg::ST_WARNING;
      else status <= gpf_pkg::ST_NORMAL;
    end
  end

  // The divider only finishes while the sequencer waits on it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a wait state");

  // A tick never moves the average.
  a_tick_keeps_avg: assert property (@(posedge clk) disable iff (rst)
    (accept && !kind) |=> $stable(avg))
    else $error("tick changed the average");

  // A waiting result holds its fields until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(filtered_ppm) && $stable(status) && $stable(warmed_up)))
    else $error("waiting result changed before it was taken");

endmodule
